// ===== rtl/rpcm_pkg.sv =====
// Package for the RSN pairwise cipher mask block.
// Holds the walk phase type, the result type and the shared constants.
// No dependencies; every other RTL file imports it.
package rpcm_pkg;

    localparam int MAX_SUITES = 16;
    localparam int BYTE_W     = 8;
    localparam int MASK_W     = 16;
    localparam int TAKEN_W    = $clog2(MAX_SUITES + 1);
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 24;

    localparam logic [BYTE_W-1:0] RESET_TARGET_ID = 8'd48;
    localparam logic [BYTE_W-1:0] COUNT_LO_OFFSET = 8'd8;
    localparam logic [BYTE_W-1:0] COUNT_HI_OFFSET = 8'd9;
    localparam logic [BYTE_W-1:0] FIRST_TYPE_OFFSET = 8'd13;
    localparam logic [BYTE_W-1:0] BODY_START_OFFSET = 8'd2;
    localparam logic [BYTE_W-1:0] OFFSET_MAX = 8'd255;

    typedef enum logic [4:0] {
        PH_ID     = 5'b00001,
        PH_LEN    = 5'b00010,
        PH_SKIP   = 5'b00100,
        PH_TARGET = 5'b01000,
        PH_DONE   = 5'b10000
    } phase_t;

    typedef struct packed {
        logic              element_found;
        logic [MASK_W-1:0] cipher_mask;
    } result_t;

endpackage

// ===== rtl/rsn_pairwise_cipher_mask.sv =====
// Top level of the RSN pairwise cipher mask block.
// Input register, element walker and result register; uses rpcm_pkg and rpcm_walker.
//
// Channel  | Direction | Handshake               | Payload
// s_axis   | in        | s_axis_tvalid/tready    | tdata[7:0] ie_byte, tlast last_byte
// m_axis   | out       | m_axis_tvalid/tready    | tdata[0] element_found, [16:1] cipher_mask
// cfg      | in        | cfg_valid/cfg_ready     | cfg_data[7:0] target_element_id
//
// One item per cycle is accepted unless the last byte stalls; walk state updates per byte.
// The result of a last byte is written into the result register once that register is free.
// Only the last byte of a frame stalls when the result register is still full.
// Reset clears the walk state and sets the target id to 48.
module rsn_pairwise_cipher_mask
    import rpcm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [7:0] ie_byte
    input  logic                  s_axis_tlast,   // last_byte
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [0] element_found, [16:1] cipher_mask
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [BYTE_W-1:0]     cfg_data
);

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;
    logic [BYTE_W-1:0] target_reg;
    logic              out_valid_reg;
    result_t           out_data_reg;
    result_t           walk_result;
    logic              advance;

    assign advance       = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= RESET_TARGET_ID;
        end
        else if (cfg_valid)
        begin
            target_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata[BYTE_W-1:0];
            in_last_reg <= s_axis_tlast;
        end
    end

    rpcm_walker u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .in_byte   (in_byte_reg),
        .in_last   (in_last_reg),
        .target_id (target_reg),
        .result    (walk_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            out_data_reg <= walk_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - MASK_W - 1){1'b0}},
                            out_data_reg.cipher_mask, out_data_reg.element_found};

    a_mask_needs_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_data_reg.element_found |-> out_data_reg.cipher_mask == '0)
        else $error("Mask set without a found element.");

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_valid_reg && in_last_reg))
        else $error("Result appeared without a last byte.");

    a_no_accept_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |-> !s_axis_tready && out_valid_reg)
        else $error("Item taken while the last byte is blocked.");

endmodule

// ===== rtl/rpcm_walker.sv =====
// Element walker: keeps the parse state of one frame and updates it per byte.
// Produces the frame result combinationally for the byte marked last.
// Depends on rpcm_pkg.
module rpcm_walker
    import rpcm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              in_last,
    input  logic [BYTE_W-1:0] target_id,
    output result_t           result
);

    phase_t             phase_reg, phase_next, phase_upd;
    logic [BYTE_W-1:0]  left_reg, left_next, left_upd;
    logic [BYTE_W-1:0]  offset_reg, offset_next, offset_upd;
    logic               found_reg, found_next, found_upd;
    logic [BYTE_W-1:0]  count_reg, count_next, count_upd;
    logic [TAKEN_W-1:0] taken_reg, taken_next, taken_upd;
    logic [MASK_W-1:0]  mask_reg, mask_next, mask_upd;
    logic [BYTE_W-1:0]  cur_id_reg, cur_id_next, cur_id_upd;
    logic [2*BYTE_W-1:0] full_count;
    logic [BYTE_W-1:0]  left_dec;

    assign full_count = {in_byte, count_reg};
    assign left_dec   = left_reg - 8'd1;

    always_comb
    begin
        phase_upd  = phase_reg;
        left_upd   = left_reg;
        offset_upd = offset_reg;
        found_upd  = found_reg;
        count_upd  = count_reg;
        taken_upd  = taken_reg;
        mask_upd   = mask_reg;
        cur_id_upd = cur_id_reg;
        unique case (phase_reg)
            PH_ID:
            begin
                cur_id_upd = in_byte;
                phase_upd  = PH_LEN;
            end
            PH_LEN:
            begin
                if (cur_id_reg == target_id)
                begin
                    if (in_byte == '0 || in_last)
                    begin
                        phase_upd = PH_DONE;
                    end
                    else
                    begin
                        found_upd  = 1'b1;
                        left_upd   = in_byte;
                        offset_upd = BODY_START_OFFSET;
                        phase_upd  = PH_TARGET;
                    end
                end
                else if (in_byte == '0)
                begin
                    phase_upd = PH_ID;
                end
                else
                begin
                    left_upd  = in_byte;
                    phase_upd = PH_SKIP;
                end
            end
            PH_SKIP:
            begin
                left_upd = left_dec;
                if (left_dec == '0)
                begin
                    phase_upd = PH_ID;
                end
            end
            PH_TARGET:
            begin
                if (offset_reg == COUNT_LO_OFFSET)
                begin
                    count_upd = in_byte;
                end
                else if (offset_reg == COUNT_HI_OFFSET)
                begin
                    if (full_count > 16'(MAX_SUITES))
                    begin
                        count_upd = BYTE_W'(MAX_SUITES);
                    end
                end
                else if (offset_reg >= FIRST_TYPE_OFFSET && offset_reg[1:0] == 2'b01)
                begin
                    if (BYTE_W'(taken_reg) < count_reg)
                    begin
                        if (in_byte[7:4] == 4'd0)
                        begin
                            mask_upd = mask_reg | (MASK_W'(1) << in_byte[3:0]);
                        end
                        taken_upd = taken_reg + TAKEN_W'(1);
                    end
                end
                if (offset_reg != OFFSET_MAX)
                begin
                    offset_upd = offset_reg + 8'd1;
                end
                left_upd = left_dec;
                if (left_dec == '0)
                begin
                    phase_upd = PH_DONE;
                end
            end
            PH_DONE:
            begin
                phase_upd = PH_DONE;
            end
            default:
            begin
                phase_upd = PH_ID;
            end
        endcase
    end

    always_comb
    begin
        result.element_found = found_upd;
        result.cipher_mask   = found_upd ? mask_upd : '0;
        if (in_last)
        begin
            phase_next  = PH_ID;
            left_next   = '0;
            offset_next = '0;
            found_next  = 1'b0;
            count_next  = '0;
            taken_next  = '0;
            mask_next   = '0;
            cur_id_next = '0;
        end
        else
        begin
            phase_next  = phase_upd;
            left_next   = left_upd;
            offset_next = offset_upd;
            found_next  = found_upd;
            count_next  = count_upd;
            taken_next  = taken_upd;
            mask_next   = mask_upd;
            cur_id_next = cur_id_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_ID;
            left_reg   <= '0;
            offset_reg <= '0;
            found_reg  <= 1'b0;
            count_reg  <= '0;
            taken_reg  <= '0;
            mask_reg   <= '0;
            cur_id_reg <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            left_reg   <= left_next;
            offset_reg <= offset_next;
            found_reg  <= found_next;
            count_reg  <= count_next;
            taken_reg  <= taken_next;
            mask_reg   <= mask_next;
            cur_id_reg <= cur_id_next;
        end
    end

endmodule
